// ===== rtl/core/i2c_register_access_sequencer_macros.svh =====
// assertion macros for the i2c register access sequencer
// used by the top level only; no other dependencies
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define RAS_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication failed");

// next-cycle implication, checked out of reset
`define RAS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle implication failed");

`else

`define RAS_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define RAS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== rtl/core/i2c_ras_pkg.sv =====
// shared types and codes for the i2c register access sequencer
// no dependencies
`timescale 1ns / 1ps

package i2c_ras_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_START  = 2'd1,
		REQ_STATUS = 2'd2,
		REQ_UNUSED = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_ACK     = 3'd3,
		CMD_NACK_TX = 3'd4
	} bus_cmd_t;

	localparam logic [7:0] ST_START     = 8'd8;
	localparam logic [7:0] ST_REP_START = 8'd16;
	localparam logic [7:0] ST_SLAW_ACK  = 8'd24;
	localparam logic [7:0] ST_DATA_ACK  = 8'd40;
	localparam logic [7:0] ST_SLAR_ACK  = 8'd64;
	localparam logic [7:0] ST_RX_ACK    = 8'd80;
	localparam logic [7:0] ST_RX_NACK   = 8'd88;

	typedef struct packed {
		logic [1:0] req_type;
		logic       direction;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] transfer_size;
		logic [7:0] load_index;
		logic [7:0] load_byte;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
	} ras_req_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] bus_command;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       recv_valid;
		logic [7:0] recv_index;
		logic [7:0] recv_byte;
		logic       busy_res;
		logic       done_res;
	} ras_rsp_t;

endpackage

// ===== rtl/core/i2c_ras_if.sv =====
// valid/ready channel interfaces for the i2c register access sequencer
// depends on i2c_ras_pkg
`timescale 1ns / 1ps

interface i2c_ras_req_if;
	logic                 valid;
	logic                 ready;
	i2c_ras_pkg::ras_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2c_ras_rsp_if;
	logic                 valid;
	logic                 ready;
	i2c_ras_pkg::ras_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/i2c_register_access_sequencer.sv =====
// top level of the i2c register access sequencer: control state, write buffer
// depends on i2c_ras_pkg, i2c_ras_if and the assertion macro header
`timescale 1ns / 1ps
`include "i2c_register_access_sequencer_macros.svh"

// Usage
// req channel: load, start and bus status transactions; rsp channel: one
// result per accepted request, in order.
// A load writes the write buffer, a start arms a transfer and asks for START,
// each status event yields the next bus command, a byte to send or a
// received byte with its index. A start while busy comes back with
// accepted low.
// The result is registered and valid in the cycle after a request is taken.
// Throughput: one request per cycle while rsp is taken. The write buffer is a
// synchronous RAM with one write and one read port; the read for the next data
// byte is launched as the status request is taken and its registered data
// feeds the result, so a load followed directly by a send of that entry is seen.
// The result register is refilled in the cycle it is drained, so req.ready
// stays high as long as rsp is taken; a stalled rsp holds its result and
// drops req.ready until it is taken.
// Reset clears busy and the transfer registers; the buffer is not cleared
// and needs no sweep: an unloaded entry reads as garbage.
module i2c_register_access_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	i2c_ras_req_if.sink    req,
	i2c_ras_rsp_if.source  rsp
);
	import i2c_ras_pkg::*;

	logic [7:0] write_buffer [BUFFER_DEPTH];
	logic [7:0] rd_data_s1;

	logic       busy_q, busy_d;
	logic       read_mode_q, read_mode_d;
	logic [6:0] target_address_q, target_address_d;
	logic [7:0] target_register_q, target_register_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [8:0] byte_position_q, byte_position_d;

	logic       valid_s1;
	ras_rsp_t   res_s1, res_d;
	logic       mem_sel_s1, mem_sel_d;

	logic       fire;
	logic       wr_en;
	logic [8:0] pos_adv;
	logic [7:0] rsize_m1;
	ras_req_t   r;

	assign r     = req.data;
	assign req.ready = !valid_s1 || rsp.ready;
	assign fire  = req.valid && req.ready;

	// saturating advance of the byte position
	assign pos_adv  = (byte_position_q < 9'd256) ? byte_position_q + 9'd1 : byte_position_q;
	// read size minus one, size zero counts as one
	assign rsize_m1 = (byte_count_q == 8'd0) ? 8'd0 : byte_count_q - 8'd1;

	always_comb begin
		res_d             = '0;
		res_d.accepted    = 1'b1;
		mem_sel_d         = 1'b0;
		wr_en             = 1'b0;
		busy_d            = busy_q;
		read_mode_d       = read_mode_q;
		target_address_d  = target_address_q;
		target_register_d = target_register_q;
		byte_count_d      = byte_count_q;
		byte_position_d   = byte_position_q;
		unique case (req_type_t'(r.req_type))
			REQ_LOAD: begin
				wr_en = ({1'b0, r.load_index} < 9'(BUFFER_DEPTH));
			end
			REQ_START: begin
				if (busy_q) begin
					res_d.accepted = 1'b0;
				end else begin
					read_mode_d       = r.direction;
					target_address_d  = r.device_address;
					target_register_d = r.register_address;
					byte_count_d      = r.transfer_size;
					busy_d            = 1'b1;
					res_d.bus_command = CMD_START;
				end
			end
			REQ_STATUS: begin
				if (busy_q) begin
					unique case (r.bus_status)
						ST_START: begin
							byte_position_d   = 9'd0;
							res_d.bus_command = CMD_NACK_TX;
							res_d.send_valid  = 1'b1;
							res_d.send_byte   = {target_address_q, 1'b0};
						end
						ST_SLAW_ACK: begin
							res_d.bus_command = CMD_NACK_TX;
							res_d.send_valid  = 1'b1;
							res_d.send_byte   = target_register_q;
						end
						ST_DATA_ACK: begin
							if (read_mode_q) begin
								res_d.bus_command = CMD_START;
							end else if (byte_position_q < {1'b0, byte_count_q}) begin
								res_d.bus_command = CMD_NACK_TX;
								res_d.send_valid  = 1'b1;
								// byte comes from the buffer read launched now
								mem_sel_d         = (byte_position_q < 9'(BUFFER_DEPTH));
								byte_position_d   = pos_adv;
							end else begin
								res_d.bus_command = CMD_STOP;
								res_d.done_res    = 1'b1;
								busy_d            = 1'b0;
							end
						end
						ST_REP_START: begin
							res_d.bus_command = CMD_NACK_TX;
							res_d.send_valid  = 1'b1;
							res_d.send_byte   = {target_address_q, 1'b1};
						end
						ST_SLAR_ACK: begin
							res_d.bus_command = (byte_count_q <= 8'd1) ? CMD_NACK_TX : CMD_ACK;
						end
						ST_RX_ACK: begin
							res_d.recv_valid  = 1'b1;
							res_d.recv_index  = byte_position_q[8] ? 8'hFF : byte_position_q[7:0];
							res_d.recv_byte   = r.bus_data;
							byte_position_d   = pos_adv;
							res_d.bus_command = (pos_adv < {1'b0, rsize_m1}) ? CMD_ACK : CMD_NACK_TX;
						end
						ST_RX_NACK: begin
							res_d.recv_valid  = 1'b1;
							res_d.recv_index  = byte_position_q[8] ? 8'hFF : byte_position_q[7:0];
							res_d.recv_byte   = r.bus_data;
							res_d.bus_command = CMD_STOP;
							res_d.done_res    = 1'b1;
							busy_d            = 1'b0;
						end
						default: begin
							res_d.bus_command = CMD_STOP;
							res_d.done_res    = 1'b1;
							busy_d            = 1'b0;
						end
					endcase
				end
			end
			default: begin
				res_d.accepted = 1'b0;
			end
		endcase
		res_d.busy_res = busy_d;
	end

	// write buffer: one write port for loads, one registered read port
	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			write_buffer[r.load_index[BUF_AW-1:0]] <= r.load_byte;
		end
		if (fire) begin
			rd_data_s1 <= write_buffer[byte_position_q[BUF_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q            <= 1'b0;
			read_mode_q       <= 1'b0;
			target_address_q  <= '0;
			target_register_q <= '0;
			byte_count_q      <= '0;
			byte_position_q   <= '0;
			valid_s1          <= 1'b0;
		end else begin
			if (fire) begin
				busy_q            <= busy_d;
				read_mode_q       <= read_mode_d;
				target_address_q  <= target_address_d;
				target_register_q <= target_register_d;
				byte_count_q      <= byte_count_d;
				byte_position_q   <= byte_position_d;
				valid_s1          <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1     <= res_d;
			mem_sel_s1 <= mem_sel_d;
		end
	end

	always_comb begin
		rsp.data = res_s1;
		if (mem_sel_s1) begin
			rsp.data.send_byte = rd_data_s1;
		end
	end
	assign rsp.valid = valid_s1;

	`RAS_ASSERT_IMPLIES(a_done_clears_busy, clk, arst_n, valid_s1 && res_s1.done_res, !res_s1.busy_res && (res_s1.bus_command == CMD_STOP))
	`RAS_ASSERT_NEXT(a_start_busy_rejected, clk, arst_n, fire && (r.req_type == REQ_START) && busy_q, !res_s1.accepted && (res_s1.bus_command == CMD_NONE))
	`RAS_ASSERT_IMPLIES(a_busy_falls_on_done, clk, arst_n, $fell(busy_q), valid_s1 && res_s1.done_res)
	`RAS_ASSERT_IMPLIES(a_mem_sel_sends, clk, arst_n, valid_s1 && mem_sel_s1, res_s1.send_valid && !read_mode_q)

endmodule
